### hdl/serial_clock_card_interface_assert.svh
// Assertion macros shared by the serial clock card interface RTL.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef SERIAL_CLOCK_CARD_INTERFACE_ASSERT_SVH
`define SERIAL_CLOCK_CARD_INTERFACE_ASSERT_SVH

// Same-cycle implication, ignored while in reset.
`define SCCIF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sccif: same-cycle check failed");

// Next-cycle implication, ignored while in reset.
`define SCCIF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sccif: next-cycle check failed");

`endif

### hdl/sccif_pkg.sv
// Package for the serial clock card interface: item/result types, codes, constants.
// No dependencies.
package sccif_pkg;

    localparam int DIGIT_COUNT = 10;
    localparam int BIT_COUNT   = 4 * DIGIT_COUNT;
    localparam int IDX_W       = $clog2(BIT_COUNT);
    localparam int DIG_W       = $clog2(DIGIT_COUNT);

    // Item kinds carried in tuser
    typedef enum logic [1:0] {
        ITEM_BUS_WRITE = 2'd0,
        ITEM_BUS_READ  = 2'd1,
        ITEM_TICK      = 2'd2,
        ITEM_RESET     = 2'd3
    } item_kind_t;

    // Sequence request in command bits 5:4
    typedef enum logic [1:0] {
        SEQ_NONE       = 2'b00,
        SEQ_READ       = 2'b01,
        SEQ_WRITE      = 2'b10,
        SEQ_READ_WRITE = 2'b11
    } seq_kind_t;

    typedef enum logic [1:0] {
        RATE_64HZ   = 2'd0,
        RATE_256HZ  = 2'd1,
        RATE_2048HZ = 2'd2,
        RATE_NONE   = 2'd3
    } tick_rate_t;

    // Register offsets
    localparam logic [3:0] OFFS_CMD     = 4'd0;
    localparam logic [3:0] OFFS_INT_CLR = 4'd8;

    // Command byte bits
    localparam int CMD_DATA_BIT   = 0;
    localparam int CMD_CLOCK_BIT  = 1;
    localparam int CMD_STROBE_BIT = 2;
    localparam int CMD_SHIFT_BIT  = 3;
    localparam int CMD_INT_EN_BIT = 6;

    // Mode codes that select a tick rate
    localparam logic [7:0] CODE_RATE_64   = 8'h24;
    localparam logic [7:0] CODE_RATE_256  = 8'h2C;
    localparam logic [7:0] CODE_RATE_2048 = 8'h34;

    // Status byte pieces
    localparam logic [7:0] STAT_TIME_BIT  = 8'h80;
    localparam logic [7:0] STAT_PARITY    = 8'h40;
    localparam logic [7:0] STAT_RATE_64   = 8'h20;
    localparam logic [7:0] STAT_RATE_256  = 8'h28;
    localparam logic [7:0] STAT_RATE_2048 = 8'h30;
    localparam logic [7:0] STAT_INT_FLAG  = 8'h20;

    localparam logic [1:0] WRITE_PASSES = 2'd2;

    typedef struct packed {
        logic [BIT_COUNT-1:0] clock_digits;
        logic [7:0]           write_data;
        logic [3:0]           reg_offset;
        item_kind_t           mode;
    } sccif_item_t;

    typedef struct packed {
        tick_rate_t           tick_rate;
        logic [BIT_COUNT-1:0] set_time_digits;
        logic                 set_time_valid;
        logic                 irq_level;
        logic [7:0]           read_data;
    } sccif_result_t;

endpackage

### hdl/sccif_core.sv
// Card state registers and the per-beat update logic of the clock card interface.
// Depends on sccif_pkg.
module sccif_core
    import sccif_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step_en,
    input  sccif_item_t   item,
    output sccif_result_t result
);

    logic [7:0]           cmd_reg, cmd_next;
    logic [7:0]           latched_reg, latched_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [BIT_COUNT-1:0] rdig_reg, rdig_next;
    logic [BIT_COUNT-1:0] wdig_reg, wdig_next;
    logic [1:0]           passes_reg, passes_next;
    logic                 int_en_reg, int_en_next;
    logic                 int_flag_reg, int_flag_next;
    logic                 parity_reg, parity_next;
    tick_rate_t           rate_reg, rate_next;

    logic [7:0]           changed;
    logic                 strobe_rise;
    logic                 clock_rise;
    logic [DIG_W-1:0]     wr_digit;
    logic [BIT_COUNT-1:0] wr_mask;
    logic                 done;
    logic [(1<<IDX_W)-1:0] rdig_ext;
    logic                 time_bit;
    logic [7:0]           status;

    assign changed     = cmd_reg ^ item.write_data;
    assign strobe_rise = changed[CMD_STROBE_BIT] & item.write_data[CMD_STROBE_BIT];
    assign clock_rise  = changed[CMD_CLOCK_BIT] & item.write_data[CMD_CLOCK_BIT];

    // Status byte, from state before this beat (a read changes nothing here)
    assign rdig_ext = {{((1<<IDX_W)-BIT_COUNT){1'b0}}, rdig_reg};
    assign time_bit = (idx_reg < IDX_W'(BIT_COUNT)) && rdig_ext[idx_reg];

    always_comb begin
        status = 8'h00;
        if (time_bit) begin
            status = status | STAT_TIME_BIT;
        end
        if (parity_reg) begin
            status = status | STAT_PARITY;
        end
        case (rate_reg)
            RATE_64HZ:   status = status | STAT_RATE_64;
            RATE_256HZ:  status = status | STAT_RATE_256;
            RATE_2048HZ: status = status | STAT_RATE_2048;
            default:     status = status;
        endcase
        if (int_flag_reg) begin
            status = status | STAT_INT_FLAG;
        end
    end

    always_comb begin
        cmd_next      = cmd_reg;
        latched_next  = latched_reg;
        idx_next      = idx_reg;
        rdig_next     = rdig_reg;
        wdig_next     = wdig_reg;
        passes_next   = passes_reg;
        int_en_next   = int_en_reg;
        int_flag_next = int_flag_reg;
        parity_next   = parity_reg;
        rate_next     = rate_reg;
        done          = 1'b0;
        wr_digit      = '0;
        wr_mask       = '0;

        case (item.mode)
            ITEM_BUS_WRITE: begin
                if (item.reg_offset == OFFS_CMD) begin
                    cmd_next    = item.write_data;
                    int_en_next = item.write_data[CMD_INT_EN_BIT];
                    if (strobe_rise) begin
                        latched_next = item.write_data;
                        if (item.write_data == CODE_RATE_64) begin
                            rate_next = RATE_64HZ;
                        end else if (item.write_data == CODE_RATE_256) begin
                            rate_next = RATE_256HZ;
                        end else if (item.write_data == CODE_RATE_2048) begin
                            rate_next = RATE_2048HZ;
                        end
                        case (seq_kind_t'(item.write_data[5:4]))
                            SEQ_READ: begin
                                rdig_next   = item.clock_digits;
                                idx_next    = '0;
                                passes_next = '0;
                            end
                            SEQ_WRITE: begin
                                idx_next    = IDX_W'(BIT_COUNT - 4);
                                passes_next = WRITE_PASSES;
                                wdig_next   = '0;
                            end
                            SEQ_READ_WRITE: begin
                                rdig_next   = item.clock_digits;
                                idx_next    = '0;
                                passes_next = WRITE_PASSES;
                                wdig_next   = '0;
                            end
                            default: ;
                        endcase
                    end
                    if (clock_rise) begin
                        // Bits go in most significant digit first, low bit first in a digit
                        wr_digit = DIG_W'(DIGIT_COUNT - 1) - DIG_W'(idx_next[IDX_W-1:2]);
                        wr_mask  = BIT_COUNT'(1) << {wr_digit, idx_next[1:0]};
                        if (passes_next != 2'd0 && idx_next < IDX_W'(BIT_COUNT)) begin
                            if (item.write_data[CMD_DATA_BIT]) begin
                                wdig_next = wdig_next | wr_mask;
                            end else begin
                                wdig_next = wdig_next & ~wr_mask;
                            end
                        end
                        if (latched_next[CMD_SHIFT_BIT]) begin
                            if (idx_next >= IDX_W'(BIT_COUNT - 1)) begin
                                idx_next = '0;
                                if (passes_next != 2'd0) begin
                                    passes_next = passes_next - 2'd1;
                                    done        = (passes_next == 2'd0);
                                end
                            end else begin
                                idx_next = idx_next + IDX_W'(1);
                            end
                        end
                    end
                end else if (item.reg_offset == OFFS_INT_CLR) begin
                    int_flag_next = 1'b0;
                end
            end
            ITEM_BUS_READ: begin
                if (item.reg_offset == OFFS_INT_CLR) begin
                    int_flag_next = 1'b0;
                end
            end
            ITEM_TICK: begin
                parity_next = ~parity_reg;
                if (int_en_reg) begin
                    int_flag_next = 1'b1;
                end
            end
            default: begin
                int_en_next = 1'b0;
            end
        endcase
    end

    always_comb begin
        result.read_data = ((item.mode == ITEM_BUS_READ) && (item.reg_offset == OFFS_CMD))
                         ? status : 8'h00;
        result.irq_level       = int_flag_next;
        result.set_time_valid  = done;
        result.set_time_digits = done ? wdig_next : '0;
        result.tick_rate       = rate_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg      <= '0;
            latched_reg  <= '0;
            idx_reg      <= '0;
            rdig_reg     <= '0;
            wdig_reg     <= '0;
            passes_reg   <= '0;
            int_en_reg   <= 1'b0;
            int_flag_reg <= 1'b0;
            parity_reg   <= 1'b0;
            rate_reg     <= RATE_64HZ;
        end else if (step_en) begin
            cmd_reg      <= cmd_next;
            latched_reg  <= latched_next;
            idx_reg      <= idx_next;
            rdig_reg     <= rdig_next;
            wdig_reg     <= wdig_next;
            passes_reg   <= passes_next;
            int_en_reg   <= int_en_next;
            int_flag_reg <= int_flag_next;
            parity_reg   <= parity_next;
            rate_reg     <= rate_next;
        end
    end

endmodule

### hdl/serial_clock_card_interface.sv
// Top level of the serial clock card interface: input beat register, card core, result register.
// Depends on sccif_pkg, sccif_core and serial_clock_card_interface_assert.svh.
//
//  channel  | dir | beat contents
//  ---------+-----+-------------------------------------------------------------
//  s_       | in  | tuser: mode; tdata: reg_offset, write_data, clock_digits
//  m_       | out | tdata: read_data, irq_level, set_time_valid, digits, rate
//
// One beat per cycle sustained while m_tready holds high; each accepted beat passes
// through the input register, then the result register. The card core is one level of
// register-update logic between them.
// Reset (aresetn low, synchronous) clears all card state and both valid flags.
// A stalled m_ side holds its result; one more beat waits in the input register,
// after which s_tready drops until the result is taken.
`include "serial_clock_card_interface_assert.svh"

module serial_clock_card_interface
    import sccif_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // [3:0] reg_offset, [11:4] write_data,
                                  // [51:12] clock_digits, [55:52] zero
    input  logic [1:0]  s_tuser,  // [1:0] mode

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata   // [7:0] read_data, [8] irq_level, [9] set_time_valid,
                                  // [49:10] set_time_digits, [51:50] tick_rate, [55:52] zero
);

    // Input beat register
    logic          in_valid_reg;
    sccif_item_t   in_item_reg;

    // Result register
    logic          out_valid_reg;
    sccif_result_t out_res_reg;

    sccif_result_t core_res;
    logic          advance;

    // Item moves into the core when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.mode         <= item_kind_t'(s_tuser);
            in_item_reg.reg_offset   <= s_tdata[3:0];
            in_item_reg.write_data   <= s_tdata[11:4];
            in_item_reg.clock_digits <= s_tdata[51:12];
        end
    end

    sccif_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .result  (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000,
                       out_res_reg.tick_rate,
                       out_res_reg.set_time_digits,
                       out_res_reg.set_time_valid,
                       out_res_reg.irq_level,
                       out_res_reg.read_data};

    // An empty result register never blocks the input side
    `SCCIF_ASSERT_NOW(a_ready_when_drained, !out_valid_reg, s_tready)
    // Only a status read of the command offset returns a nonzero byte
    `SCCIF_ASSERT_NEXT(a_read_data_only_on_status, advance && !(in_item_reg.mode == ITEM_BUS_READ && in_item_reg.reg_offset == OFFS_CMD), out_res_reg.read_data == 8'h00)
    // Interrupt clear access drops the request line in its own result
    `SCCIF_ASSERT_NEXT(a_int_clear, advance && (in_item_reg.mode == ITEM_BUS_WRITE || in_item_reg.mode == ITEM_BUS_READ) && in_item_reg.reg_offset == OFFS_INT_CLR, !out_res_reg.irq_level)
    // Written time shows only with its completion flag
    `SCCIF_ASSERT_NOW(a_digits_only_when_done, out_valid_reg && !out_res_reg.set_time_valid, out_res_reg.set_time_digits == '0)
    // Rate never takes the unused code
    `SCCIF_ASSERT_NOW(a_rate_code_legal, out_valid_reg, out_res_reg.tick_rate != RATE_NONE)

endmodule

### test/serial_clock_card_interface_tb.sv
// Self-checking bench for serial_clock_card_interface: directed and random command/status traffic.
// Depends on sccif_pkg and the serial_clock_card_interface RTL; carries its own card predictor.
module serial_clock_card_interface_tb;
    import sccif_pkg::*;

    // ---------------------------------------------------------------------------------------------
    // Bench constants
    // ---------------------------------------------------------------------------------------------
    localparam int RESET_CYCLES = 6;
    localparam int MAX_GAP      = 17;    // longest sender gap / receiver stall, in cycles
    localparam int ITEM_TARGET  = 1100;  // beats the block acts on, directed part included
    localparam int IDLE_LIMIT   = 1000;  // cycles without any beat before the run is called dead
    localparam int TAIL_CYCLES  = 8;     // margin for stray beats once the pipe has drained

    localparam int SEQ_FIELD_LSB = 4;    // command bits 5:4 pick the sequence
    localparam int CMD_SPARE_BIT = 7;    // not decoded, but still part of the latched mode

    localparam logic [7:0] CLOCK_MASK  = 8'(1 << CMD_CLOCK_BIT);
    localparam logic [7:0] STROBE_MASK = 8'(1 << CMD_STROBE_BIT);
    localparam logic [7:0] INT_EN_MASK = 8'(1 << CMD_INT_EN_BIT);

    localparam logic [BIT_COUNT-1:0] TIME_ALL_ONES = '1;
    localparam logic [BIT_COUNT-1:0] TIME_SAMPLE   = 40'h12_3159_2358;
    localparam int RESULT_W = $bits(sccif_result_t);

    // ---------------------------------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ---------------------------------------------------------------------------------------------
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;   // [3:0] reg_offset, [11:4] write_data, [51:12] clock_digits
    logic [1:0]  s_tuser  = '0;   // [1:0] mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;         // [7:0] read_data, [8] irq_level, [9] set_time_valid,
                                  // [49:10] set_time_digits, [51:50] tick_rate

    serial_clock_card_interface uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    // ---------------------------------------------------------------------------------------------
    // Card predictor state (mirrors the card registers, all zero out of reset)
    // ---------------------------------------------------------------------------------------------
    logic [7:0]           cmd_reg       = '0;
    logic [7:0]           mode_latch    = '0;
    logic [5:0]           shift_pos     = '0;
    logic [BIT_COUNT-1:0] captured_time = '0;
    logic [BIT_COUNT-1:0] loaded_time   = '0;
    logic [1:0]           passes_left   = '0;
    logic                 irq_enabled   = 1'b0;
    logic                 irq_pending   = 1'b0;
    logic                 tick_toggle   = 1'b0;
    tick_rate_t           rate_code     = RATE_64HZ;

    sccif_result_t pending_replies[$];   // one expected reply per accepted input beat
    int            fail_count  = 0;
    int            items_sent  = 0;      // beats the card acts on
    int            max_gap     = MAX_GAP;
    int unsigned   sink_wait   = 0;
    int            quiet_cycles = 0;

    // Command byte write: strobe edge latches mode/rate and arms a sequence, clock edge
    // moves one bit. Strobe handling comes first so a combined edge shifts in the new mode.
    task automatic apply_command(input logic [7:0] data, input logic [BIT_COUNT-1:0] digits,
                                 output logic done);
        logic [7:0]  toggled;
        int unsigned pos;
        int unsigned next_pos;
        done    = 1'b0;
        toggled = cmd_reg ^ data;
        cmd_reg = data;
        irq_enabled = data[CMD_INT_EN_BIT];

        if (toggled[CMD_STROBE_BIT] && data[CMD_STROBE_BIT]) begin
            mode_latch = data;
            if (data == CODE_RATE_64) rate_code = RATE_64HZ;
            else if (data == CODE_RATE_256) rate_code = RATE_256HZ;
            else if (data == CODE_RATE_2048) rate_code = RATE_2048HZ;
            case (seq_kind_t'(data[SEQ_FIELD_LSB +: 2]))
                SEQ_READ: begin
                    captured_time = digits;
                    shift_pos     = '0;
                    passes_left   = '0;
                end
                SEQ_WRITE: begin
                    shift_pos   = 6'(BIT_COUNT - 4);
                    passes_left = WRITE_PASSES;
                    loaded_time = '0;
                end
                SEQ_READ_WRITE: begin
                    captured_time = digits;
                    shift_pos     = '0;
                    passes_left   = WRITE_PASSES;
                    loaded_time   = '0;
                end
                default: ;
            endcase
        end

        if (toggled[CMD_CLOCK_BIT] && data[CMD_CLOCK_BIT]) begin
            // bit order inside the write image is digit-reversed, bit-forward
            if (passes_left != 0 && shift_pos < BIT_COUNT) begin
                pos = 4 * (DIGIT_COUNT - 1 - shift_pos / 4) + shift_pos % 4;
                loaded_time[pos] = data[CMD_DATA_BIT];
            end
            if (mode_latch[CMD_SHIFT_BIT]) begin
                next_pos = shift_pos + 1;
                if (next_pos >= BIT_COUNT) begin
                    if (passes_left != 0) begin
                        passes_left = passes_left - 1;
                        if (passes_left == 0) done = 1'b1;
                    end
                    next_pos = 0;
                end
                shift_pos = 6'(next_pos);
            end
        end
    endtask

    function automatic logic [7:0] card_status();
        logic [7:0] status;
        status = '0;
        if (shift_pos < BIT_COUNT && captured_time[shift_pos]) status |= STAT_TIME_BIT;
        if (tick_toggle) status |= STAT_PARITY;
        case (rate_code)
            RATE_64HZ:   status |= STAT_RATE_64;
            RATE_256HZ:  status |= STAT_RATE_256;
            RATE_2048HZ: status |= STAT_RATE_2048;
            default: ;
        endcase
        if (irq_pending) status |= STAT_INT_FLAG;
        return status;
    endfunction

    // Advance the predictor by one accepted beat and queue the reply it owes.
    task automatic card_step(input item_kind_t kind, input logic [3:0] offs,
                             input logic [7:0] data, input logic [BIT_COUNT-1:0] digits);
        sccif_result_t reply;
        logic          done;
        reply = '0;
        done  = 1'b0;
        case (kind)
            ITEM_BUS_WRITE: begin
                if (offs == OFFS_CMD) apply_command(data, digits, done);
                else if (offs == OFFS_INT_CLR) irq_pending = 1'b0;
            end
            ITEM_BUS_READ: begin
                if (offs == OFFS_CMD) reply.read_data = card_status();
                else if (offs == OFFS_INT_CLR) irq_pending = 1'b0;
            end
            ITEM_TICK: begin
                tick_toggle = ~tick_toggle;
                if (irq_enabled) irq_pending = 1'b1;
            end
            default: irq_enabled = 1'b0;   // card reset only drops the interrupt enable
        endcase
        reply.irq_level       = irq_pending;
        reply.set_time_valid  = done;
        reply.set_time_digits = done ? loaded_time : '0;
        reply.tick_rate       = rate_code;
        pending_replies.push_back(reply);
    endtask

    // ---------------------------------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------------------------------
    function automatic int unsigned draw_gap();
        return (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
    endfunction

    function automatic logic [BIT_COUNT-1:0] rand_digits();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[BIT_COUNT-1:0];
    endfunction

    // Drive one beat on s_ and hold it until taken. tvalid is only lowered when a gap
    // is drawn, so back-to-back beats never see two assignments in one step.
    task automatic send_card_item(input item_kind_t kind, input logic [3:0] offs,
                                  input logic [7:0] data, input logic [BIT_COUNT-1:0] digits);
        int unsigned gap;
        gap = draw_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0, digits, data, offs};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        card_step(kind, offs, data, digits);
        if (kind == ITEM_TICK || kind == ITEM_RESET || offs == OFFS_CMD || offs == OFFS_INT_CLR)
            items_sent++;
    endtask

    task automatic read_reg(input logic [3:0] offs);
        send_card_item(ITEM_BUS_READ, offs, 8'($urandom), rand_digits());
    endtask

    task automatic write_cmd(input logic [7:0] data, input logic [BIT_COUNT-1:0] digits);
        send_card_item(ITEM_BUS_WRITE, OFFS_CMD, data, digits);
    endtask

    // Sender holds off until the card has answered everything in flight.
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_replies.size() != 0);
    endtask

    // Arm a sequence: strobe low, then strobe high with the capture time on the bus.
    // The clock pulses afterwards run with strobe kept high or dropped, at random.
    task automatic open_sequence(input seq_kind_t seq, input logic [BIT_COUNT-1:0] capture,
                                 output logic [7:0] shift_base);
        logic [7:0] cmd;
        cmd = '0;
        cmd[SEQ_FIELD_LSB +: 2] = seq;
        cmd[CMD_SHIFT_BIT]  = ($urandom_range(0, 7) != 0);
        cmd[CMD_INT_EN_BIT] = ($urandom_range(0, 3) == 0);
        cmd[CMD_SPARE_BIT]  = ($urandom_range(0, 3) == 0);
        write_cmd(cmd, rand_digits());
        write_cmd(cmd | STROBE_MASK, capture);
        shift_base = $urandom_range(0, 1) ? (cmd | STROBE_MASK) : cmd;
    endtask

    task automatic pulse_shift_clock(input logic [7:0] shift_base, input logic din);
        logic [7:0] low_byte;
        low_byte = shift_base;
        low_byte[CMD_DATA_BIT] = din;
        write_cmd(low_byte, rand_digits());
        write_cmd(low_byte | CLOCK_MASK, rand_digits());
    endtask

    // Occasional side traffic that must not disturb a running sequence.
    task automatic maybe_interject();
        int unsigned pick;
        if ($urandom_range(0, 7) == 0) begin
            pick = $urandom_range(0, 4);
            case (pick)
                0: send_card_item(ITEM_TICK, 4'($urandom), 8'($urandom), rand_digits());
                1: read_reg(OFFS_INT_CLR);
                2: read_reg(OFFS_CMD);
                3: send_card_item(ITEM_BUS_WRITE, OFFS_INT_CLR, 8'($urandom), rand_digits());
                default: send_card_item(ITEM_RESET, 4'($urandom), 8'($urandom), rand_digits());
            endcase
        end
    endtask

    // ---------------------------------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------------------------------
    task automatic test_reset_state();
        read_reg(OFFS_CMD);                                              // 64 Hz bits only
        read_reg(4'hF);
        send_card_item(ITEM_BUS_WRITE, 4'hF, 8'hFF, TIME_ALL_ONES);      // unused offset
        read_reg(OFFS_INT_CLR);
    endtask

    task automatic test_rate_codes();
        write_cmd(CODE_RATE_64, TIME_SAMPLE);
        write_cmd(8'h00, '0);
        write_cmd(CODE_RATE_256, TIME_SAMPLE);
        write_cmd(8'h00, '0);
        write_cmd(CODE_RATE_2048, TIME_ALL_ONES);                        // read-write, captures
        read_reg(OFFS_CMD);
        write_cmd(8'h00, '0);
        write_cmd(STROBE_MASK, '0);                                      // no sequence, rate kept
        read_reg(OFFS_CMD);
    endtask

    task automatic test_interrupts();
        write_cmd(INT_EN_MASK, '0);
        send_card_item(ITEM_TICK, 4'h0, 8'h00, '0);
        read_reg(OFFS_CMD);
        read_reg(OFFS_INT_CLR);                                          // read clears flag
        send_card_item(ITEM_TICK, 4'hF, 8'hFF, TIME_ALL_ONES);
        send_card_item(ITEM_BUS_WRITE, OFFS_INT_CLR, 8'h00, '0);         // write clears flag
        send_card_item(ITEM_RESET, 4'h0, 8'hFF, '0);                     // drops enable only
        send_card_item(ITEM_TICK, 4'h0, 8'h00, '0);
        read_reg(OFFS_CMD);
        write_cmd(8'hFF, TIME_SAMPLE);                                   // strobe and clock at once
        read_reg(OFFS_CMD);
    endtask

    task automatic run_read_sequence();
        logic [7:0]           shift_base;
        logic [BIT_COUNT-1:0] capture;
        int unsigned          bits;
        case ($urandom_range(0, 3))
            0: capture = '0;
            1: capture = TIME_ALL_ONES;
            default: capture = rand_digits();
        endcase
        bits = ($urandom_range(0, 4) == 0) ? $urandom_range(1, BIT_COUNT - 1) : BIT_COUNT;
        open_sequence(SEQ_READ, capture, shift_base);
        repeat (bits) begin
            read_reg(OFFS_CMD);
            maybe_interject();
            pulse_shift_clock(shift_base, 1'($urandom));
        end
        read_reg(OFFS_CMD);
    endtask

    task automatic run_write_sequence();
        logic [7:0]  shift_base;
        seq_kind_t   seq;
        int unsigned pulses;
        seq = $urandom_range(0, 1) ? SEQ_WRITE : SEQ_READ_WRITE;
        // mostly full double passes, a few broken off early, some run past the end
        pulses = ($urandom_range(0, 4) == 0) ? $urandom_range(1, WRITE_PASSES * BIT_COUNT - 1)
                                              : WRITE_PASSES * BIT_COUNT + $urandom_range(0, 3);
        open_sequence(seq, rand_digits(), shift_base);
        repeat (pulses) begin
            pulse_shift_clock(shift_base, 1'($urandom));
            if ($urandom_range(0, 3) == 0) read_reg(OFFS_CMD);
            maybe_interject();
        end
    endtask

    task automatic run_noise_burst();
        logic [3:0] offs;
        repeat ($urandom_range(5, 20)) begin
            case ($urandom_range(0, 3))
                0: offs = OFFS_CMD;
                1: offs = OFFS_INT_CLR;
                default: offs = 4'($urandom);
            endcase
            send_card_item(item_kind_t'($urandom_range(0, 3)), offs, 8'($urandom), rand_digits());
        end
    endtask

    task automatic test_random_traffic();
        int unsigned pick;
        int          scenario;
        scenario = 0;
        while (items_sent < ITEM_TARGET) begin
            // one scenario in four runs with no gaps on either side
            max_gap = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
            pick = $urandom_range(0, 9);
            if (pick < 3) run_read_sequence();
            else if (pick < 6) run_write_sequence();
            else run_noise_burst();
            if (scenario == 0 || $urandom_range(0, 5) == 0) hold_until_drained();
            scenario++;
        end
        max_gap = MAX_GAP;
    endtask

    // ---------------------------------------------------------------------------------------------
    // Receiver pacing: a fresh stall is drawn after every taken beat
    // ---------------------------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) sink_wait = draw_gap();
        else if (sink_wait != 0) sink_wait--;
        m_tready <= (sink_wait == 0);
    end

    function automatic void check_field(string field, logic [BIT_COUNT-1:0] want,
                                        logic [BIT_COUNT-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", field, want, got);
            fail_count++;
        end
    endfunction

    // Result checker: every m_ beat is matched against the oldest queued reply.
    always @(posedge aclk) begin : reply_checker
        sccif_result_t got;
        sccif_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = sccif_result_t'(m_tdata[RESULT_W-1:0]);
            if (pending_replies.size() == 0) begin
                $error("unexpected result beat, tdata %0h", m_tdata);
                fail_count++;
            end else begin
                want = pending_replies.pop_front();
                check_field("read_data", want.read_data, got.read_data);
                check_field("irq_level", want.irq_level, got.irq_level);
                check_field("set_time_valid", want.set_time_valid, got.set_time_valid);
                check_field("set_time_digits", want.set_time_digits, got.set_time_digits);
                check_field("tick_rate", want.tick_rate, got.tick_rate);
                check_field("tdata_pad", '0, m_tdata[55:RESULT_W]);
            end
        end
    end

    // Watchdog: a correct block never goes this long without moving a beat.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == IDLE_LIMIT) begin
                $display("FAIL serial_clock_card_interface");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_rate_codes();
        test_interrupts();
        test_random_traffic();

        // let the pipe empty, then give stray beats a chance to show up
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_replies.size() != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending_replies.size() == 0) begin
            $display("PASS serial_clock_card_interface");
        end else begin
            $display("FAIL serial_clock_card_interface");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/sccif_pkg.sv
hdl/sccif_core.sv
hdl/serial_clock_card_interface.sv
test/serial_clock_card_interface_tb.sv
